/* rtl/vqdm_pkg.sv */
// Shared types and codes for the virtqueue descriptor manager.
package vqdm_pkg;

   localparam logic [2:0] CMD_ALLOC      = 3'd0;
   localparam logic [2:0] CMD_FREE       = 3'd1;
   localparam logic [2:0] CMD_FREE_CHAIN = 3'd2;
   localparam logic [2:0] CMD_SET_LINK   = 3'd3;
   localparam logic [2:0] CMD_SUBMIT     = 3'd4;
   localparam logic [2:0] CMD_POP_USED   = 3'd5;
   localparam logic [2:0] CMD_REINIT     = 3'd6;

   localparam logic [1:0] STS_OK        = 2'd0;
   localparam logic [1:0] STS_NONE_FREE = 2'd1;
   localparam logic [1:0] STS_INVALID   = 2'd2;
   localparam logic [1:0] STS_EMPTY     = 2'd3;

   localparam int LINK_W = 17;

   typedef struct packed {
      logic clear;
      logic advance;
   } ring_ctrl_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [7:0]  granted_index;
      logic [7:0]  ring_slot;
      logic [15:0] ring_index_after;
      logic [8:0]  freed_count;
      logic [15:0] notify_queue;
      logic        notify_valid;
   } rsp_type;

endpackage

/* rtl/vqdm_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
module vqdm_ram #(
   parameter int WIDTH = 17,
   parameter int DEPTH = 8
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/vqdm_ring_index.sv */
// Ring index counter with its slot (index modulo descriptor count) tracked alongside.
module vqdm_ring_index
   import vqdm_pkg::*;
#(
   parameter int NUM_DESCRIPTORS = 8
) (
   input  logic                               clock,
   input  logic                               reset,
   input  ring_ctrl_type                      ctrl,
   output logic [15:0]                        index,
   output logic [$clog2(NUM_DESCRIPTORS)-1:0] slot
);

   localparam int IDX_W = $clog2(NUM_DESCRIPTORS);
   localparam logic [IDX_W-1:0] LAST_SLOT = IDX_W'(NUM_DESCRIPTORS - 1);

   logic [15:0]      index_ff, index_in;
   logic [IDX_W-1:0] slot_ff, slot_in;

   always_comb begin
      index_in = index_ff;
      slot_in  = slot_ff;
      if (ctrl.clear) begin
         index_in = '0;
         slot_in  = '0;
      end else if (ctrl.advance) begin
         index_in = index_ff + 16'd1;
         // 2^16 need not be a multiple of the ring size
         if (index_ff == 16'hFFFF || slot_ff == LAST_SLOT) begin
            slot_in = '0;
         end else begin
            slot_in = slot_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         index_ff <= '0;
         slot_ff  <= '0;
      end else begin
         index_ff <= index_in;
         slot_ff  <= slot_in;
      end
   end

   assign index = index_ff;
   assign slot  = slot_ff;

endmodule

/* rtl/virtqueue_descriptor_manager.sv */
// Split virtqueue descriptor manager: free map, link RAM, ring indexes, request sequencer.
// Alloc scans upward from descriptor 0 (one entry scanned a cycle) and grants the lowest free one.
// Free chain reads each link from the link RAM and stops at the chain's end or on an invalid one.
// One request in flight; the next is accepted once the response is loaded.
// Synchronous reset: all descriptors free, links cleared, indexes and queue number zero.
module virtqueue_descriptor_manager
   import vqdm_pkg::*;
#(
   parameter int NUM_DESCRIPTORS = 8
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_write_enable,
   input  logic [15:0] csr_write_data,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [2:0]  req_command,
   input  logic [15:0] req_desc_index,
   input  logic [15:0] req_link_next,
   input  logic        req_link_has_next,
   input  logic [15:0] req_device_used_idx,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_status,
   output logic [7:0]  rsp_granted_index,
   output logic [7:0]  rsp_ring_slot,
   output logic [15:0] rsp_ring_index_after,
   output logic [8:0]  rsp_freed_count,
   output logic [15:0] rsp_notify_queue,
   output logic        rsp_notify_valid
);

   localparam int IDX_W = $clog2(NUM_DESCRIPTORS);
   localparam logic [IDX_W-1:0] LAST_DESC = IDX_W'(NUM_DESCRIPTORS - 1);
   localparam logic [15:0] DESC_LIMIT = 16'(NUM_DESCRIPTORS);

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_SCAN = 3'd1;
   localparam logic [2:0] S_CHK  = 3'd2;
   localparam logic [2:0] S_LINK = 3'd3;
   localparam logic [2:0] S_DONE = 3'd4;

   logic [2:0]                 state_ff, state_in;
   logic [NUM_DESCRIPTORS-1:0] free_ff, free_in;
   logic [NUM_DESCRIPTORS-1:0] link_set_ff, link_set_in;
   logic [IDX_W-1:0]           scan_ff, scan_in;
   logic [15:0]                walk_ff, walk_in;
   logic [15:0]                queue_ff;
   rsp_type                    res_ff, res_in;
   rsp_type                    out_ff, out_in;
   logic                       out_valid_ff, out_valid_in;

   logic [IDX_W-1:0] probe;
   logic             probe_free, probe_link_set;
   logic             req_fire, out_load;
   logic             req_ok, walk_ok;

   logic             ram_wr_en, ram_rd_en;
   logic [LINK_W-1:0] ram_wr_data, ram_rd_data;
   logic             link_has;
   logic [15:0]      link_nxt;

   ring_ctrl_type    avail_ctrl, used_ctrl;
   logic [15:0]      avail_index, used_index;
   logic [IDX_W-1:0] avail_slot, used_slot;

   vqdm_ram #(
      .WIDTH (LINK_W),
      .DEPTH (NUM_DESCRIPTORS)
   ) u_link_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (req_desc_index[IDX_W-1:0]),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (walk_ff[IDX_W-1:0]),
      .rd_data (ram_rd_data)
   );

   vqdm_ring_index #(
      .NUM_DESCRIPTORS (NUM_DESCRIPTORS)
   ) u_avail (
      .clock (clock),
      .reset (reset),
      .ctrl  (avail_ctrl),
      .index (avail_index),
      .slot  (avail_slot)
   );

   vqdm_ring_index #(
      .NUM_DESCRIPTORS (NUM_DESCRIPTORS)
   ) u_used (
      .clock (clock),
      .reset (reset),
      .ctrl  (used_ctrl),
      .index (used_index),
      .slot  (used_slot)
   );

   assign req_stall = (state_ff != S_IDLE);
   assign req_fire  = req_valid && !req_stall;
   assign out_load  = (state_ff == S_DONE) && (!out_valid_ff || !rsp_stall);
   assign req_ok    = (req_desc_index < DESC_LIMIT);
   assign walk_ok   = (walk_ff < DESC_LIMIT);
   assign ram_wr_data = {req_link_has_next, req_link_next};

   always_comb begin
      unique case (state_ff)
         S_SCAN:         probe = scan_ff;
         S_CHK, S_LINK:  probe = walk_ff[IDX_W-1:0];
         default:        probe = req_desc_index[IDX_W-1:0];
      endcase
   end

   assign probe_free     = free_ff[probe];
   assign probe_link_set = link_set_ff[probe];
   // a link never written since its descriptor was last cleared reads as zero
   assign link_has = probe_link_set & ram_rd_data[LINK_W-1];
   assign link_nxt = probe_link_set ? ram_rd_data[15:0] : 16'd0;

   always_comb begin
      state_in    = state_ff;
      free_in     = free_ff;
      link_set_in = link_set_ff;
      scan_in     = scan_ff;
      walk_in     = walk_ff;
      res_in      = res_ff;
      ram_wr_en   = 1'b0;
      ram_rd_en   = 1'b0;
      avail_ctrl  = '0;
      used_ctrl   = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               res_in   = '0;
               state_in = S_DONE;
               unique case (req_command)
                  CMD_ALLOC: begin
                     scan_in  = '0;
                     state_in = S_SCAN;
                  end
                  CMD_FREE: begin
                     if (req_ok && !probe_free) begin
                        free_in[probe]     = 1'b1;
                        link_set_in[probe] = 1'b0;
                        res_in.freed_count = 9'd1;
                     end else begin
                        res_in.status = STS_INVALID;
                     end
                  end
                  CMD_FREE_CHAIN: begin
                     walk_in  = req_desc_index;
                     state_in = S_CHK;
                  end
                  CMD_SET_LINK: begin
                     if (req_ok) begin
                        ram_wr_en          = 1'b1;
                        link_set_in[probe] = 1'b1;
                     end else begin
                        res_in.status = STS_INVALID;
                     end
                  end
                  CMD_SUBMIT: begin
                     avail_ctrl.advance      = 1'b1;
                     res_in.ring_slot        = 8'(avail_slot);
                     res_in.ring_index_after = avail_index + 16'd1;
                     res_in.notify_queue     = queue_ff;
                     res_in.notify_valid     = 1'b1;
                  end
                  CMD_POP_USED: begin
                     if (used_index == req_device_used_idx) begin
                        res_in.status           = STS_EMPTY;
                        res_in.ring_index_after = used_index;
                     end else begin
                        used_ctrl.advance       = 1'b1;
                        res_in.ring_slot        = 8'(used_slot);
                        res_in.ring_index_after = used_index + 16'd1;
                     end
                  end
                  CMD_REINIT: begin
                     free_in          = '1;
                     link_set_in      = '0;
                     avail_ctrl.clear = 1'b1;
                     used_ctrl.clear  = 1'b1;
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_SCAN: begin
            if (probe_free) begin
               free_in[probe]       = 1'b0;
               res_in.granted_index = 8'(scan_ff);
               state_in             = S_DONE;
            end else if (scan_ff == LAST_DESC) begin
               res_in.status = STS_NONE_FREE;
               state_in      = S_DONE;
            end else begin
               scan_in = scan_ff + 1'b1;
            end
         end
         S_CHK: begin
            if (!walk_ok || probe_free) begin
               res_in.status = STS_INVALID;
               state_in      = S_DONE;
            end else begin
               ram_rd_en = 1'b1;
               state_in  = S_LINK;
            end
         end
         S_LINK: begin
            free_in[probe]     = 1'b1;
            link_set_in[probe] = 1'b0;
            res_in.freed_count = res_ff.freed_count + 9'd1;
            if (link_has) begin
               walk_in  = link_nxt;
               state_in = S_CHK;
            end else begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (out_load) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign out_in       = out_load ? res_ff : out_ff;
   assign out_valid_in = out_load || (out_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         free_ff      <= '1;
         link_set_ff  <= '0;
         queue_ff     <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         free_ff      <= free_in;
         link_set_ff  <= link_set_in;
         out_valid_ff <= out_valid_in;
         if (csr_write_enable) begin
            queue_ff <= csr_write_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      scan_ff <= scan_in;
      walk_ff <= walk_in;
      res_ff  <= res_in;
      out_ff  <= out_in;
   end

   assign rsp_valid            = out_valid_ff;
   assign rsp_status           = out_ff.status;
   assign rsp_granted_index    = out_ff.granted_index;
   assign rsp_ring_slot        = out_ff.ring_slot;
   assign rsp_ring_index_after = out_ff.ring_index_after;
   assign rsp_freed_count      = out_ff.freed_count;
   assign rsp_notify_queue     = out_ff.notify_queue;
   assign rsp_notify_valid     = out_ff.notify_valid;

endmodule

/* bench/tb.sv */
// Self-checking testbench for the virtqueue descriptor manager: directed, chain and ring traffic.
module tb
   import vqdm_pkg::*;
();

   localparam int NUM_DESC = 8;
   localparam int CYCLE_LIMIT = 200_000;
   localparam int HOLD_CYCLES = 300;
   localparam logic [2:0] CMD_UNUSED = 3'd7;

   typedef struct packed {
      logic [2:0]  command;
      logic [15:0] desc_index;
      logic [15:0] link_next;
      logic        link_has_next;
      logic [15:0] device_used_idx;
   } request_type;

   logic        clock = 0;
   logic        reset = 1;
   logic        csr_write_enable = 0;
   logic [15:0] csr_write_data = '0;
   logic        req_valid = 0;
   logic        req_stall;
   logic [2:0]  req_command = '0;
   logic [15:0] req_desc_index = '0;
   logic [15:0] req_link_next = '0;
   logic        req_link_has_next = 0;
   logic [15:0] req_device_used_idx = '0;
   logic        rsp_valid;
   logic        rsp_stall = 0;
   logic [1:0]  rsp_status;
   logic [7:0]  rsp_granted_index;
   logic [7:0]  rsp_ring_slot;
   logic [15:0] rsp_ring_index_after;
   logic [8:0]  rsp_freed_count;
   logic [15:0] rsp_notify_queue;
   logic        rsp_notify_valid;

   virtqueue_descriptor_manager #(.NUM_DESCRIPTORS(NUM_DESC)) dut (.*);

   always #5 clock = ~clock;

   // descriptor state as the block should hold it
   bit          desc_free [NUM_DESC];
   bit          desc_has_next [NUM_DESC];
   logic [15:0] desc_next [NUM_DESC];
   logic [15:0] avail_idx;
   logic [15:0] consumed_idx;
   logic [15:0] notify_qnum;

   request_type request_backlog [$];
   rsp_type     awaited_rsp [$];
   int          fail_count = 0;
   int          cycle_count = 0;
   bit          idle_on = 0;
   bit          hold_arm = 0;
   bit          traffic_dirty = 0;

   function automatic void clear_rings();
      for (int i = 0; i < NUM_DESC; i++) begin
         desc_free[i] = 1;
         desc_has_next[i] = 0;
         desc_next[i] = '0;
      end
      avail_idx = '0;
      consumed_idx = '0;
   endfunction

   function automatic void release_desc(logic [15:0] idx);
      desc_free[idx] = 1;
      desc_has_next[idx] = 0;
      desc_next[idx] = '0;
   endfunction

   function automatic rsp_type predict_response(request_type r);
      rsp_type     p;
      logic [15:0] idx;
      logic [15:0] nxt;
      bit          has;
      bit          done;
      p = '0;
      idx = r.desc_index;
      case (r.command)
         CMD_ALLOC: begin
            p.status = STS_NONE_FREE;
            for (int i = 0; i < NUM_DESC; i++) begin
               if (p.status == STS_NONE_FREE && desc_free[i]) begin
                  desc_free[i] = 0;
                  p.granted_index = 8'(i);
                  p.status = STS_OK;
               end
            end
         end
         CMD_FREE: begin
            if (idx < NUM_DESC && !desc_free[idx]) begin
               release_desc(idx);
               p.freed_count = 9'd1;
            end else begin
               p.status = STS_INVALID;
            end
         end
         CMD_FREE_CHAIN: begin
            done = 0;
            while (!done) begin
               if (idx >= NUM_DESC || desc_free[idx]) begin
                  p.status = STS_INVALID;
                  done = 1;
               end else begin
                  has = desc_has_next[idx];
                  nxt = desc_next[idx];
                  release_desc(idx);
                  p.freed_count = p.freed_count + 9'd1;
                  if (has)
                     idx = nxt;
                  else
                     done = 1;
               end
            end
         end
         CMD_SET_LINK: begin
            if (idx < NUM_DESC) begin
               desc_next[idx] = r.link_next;
               desc_has_next[idx] = r.link_has_next;
            end else begin
               p.status = STS_INVALID;
            end
         end
         CMD_SUBMIT: begin
            p.ring_slot = 8'(avail_idx % NUM_DESC);
            avail_idx = avail_idx + 16'd1;
            p.ring_index_after = avail_idx;
            p.notify_queue = notify_qnum;
            p.notify_valid = 1;
         end
         CMD_POP_USED: begin
            if (consumed_idx == r.device_used_idx) begin
               p.status = STS_EMPTY;
            end else begin
               p.ring_slot = 8'(consumed_idx % NUM_DESC);
               consumed_idx = consumed_idx + 16'd1;
            end
            p.ring_index_after = consumed_idx;
         end
         CMD_REINIT: begin
            clear_rings();
         end
         default: begin
         end
      endcase
      return p;
   endfunction

   function automatic logic [15:0] rand16();
      return 16'($urandom);
   endfunction

   function automatic void queue_request(logic [2:0] cmd, logic [15:0] idx,
                                         logic [15:0] lnext, logic lhas, logic [15:0] dev);
      request_type r;
      r.command = cmd;
      r.desc_index = idx;
      r.link_next = lnext;
      r.link_has_next = lhas;
      r.device_used_idx = dev;
      request_backlog.push_back(r);
   endfunction

   function automatic void queue_noise();
      int n;
      n = $urandom_range(1, 4);
      for (int i = 0; i < n; i++)
         queue_request(3'($urandom_range(0, 7)),
                       $urandom_range(0, 1) ? 16'($urandom_range(0, NUM_DESC + 1)) : rand16(),
                       $urandom_range(0, 1) ? 16'($urandom_range(0, NUM_DESC + 1)) : rand16(),
                       1'($urandom),
                       $urandom_range(0, 1) ? 16'($urandom_range(0, 3)) : rand16());
      traffic_dirty = 1;
   endfunction

   // alloc a set, link it into one or two chains, use the rings, free the chains
   function automatic void queue_chain_traffic();
      int order [NUM_DESC];
      int k;
      int split;
      int j;
      int tmp;
      int flaw;
      int n;
      bit last;
      if (traffic_dirty || $urandom_range(0, 3) == 0)
         queue_request(CMD_REINIT, rand16(), rand16(), 1'($urandom), rand16());
      traffic_dirty = 0;
      k = $urandom_range(1, NUM_DESC);
      for (int i = 0; i < k; i++) begin
         order[i] = i;
         queue_request(CMD_ALLOC, rand16(), rand16(), 1'($urandom), rand16());
      end
      if (k == NUM_DESC && $urandom_range(0, 1) == 0)
         queue_request(CMD_ALLOC, rand16(), rand16(), 1'($urandom), rand16());
      for (int i = k - 1; i > 0; i--) begin
         j = $urandom_range(0, i);
         tmp = order[i];
         order[i] = order[j];
         order[j] = tmp;
      end
      split = $urandom_range(1, k);
      flaw = $urandom_range(0, 9);
      for (int i = 0; i < k; i++) begin
         last = (i == split - 1) || (i == k - 1);
         if (!last)
            queue_request(CMD_SET_LINK, 16'(order[i]), 16'(order[i + 1]), 1, rand16());
         else if (flaw == 0)
            queue_request(CMD_SET_LINK, 16'(order[i]), 16'(order[0]), 1, rand16());
         else if (flaw == 1)
            queue_request(CMD_SET_LINK, 16'(order[i]),
                          16'($urandom_range(NUM_DESC, 16'hFFFF)), 1, rand16());
         else
            queue_request(CMD_SET_LINK, 16'(order[i]), rand16(), 0, rand16());
      end
      if (flaw == 2 && k > 1)
         queue_request(CMD_FREE, 16'(order[$urandom_range(1, k - 1)]), rand16(), 1'($urandom),
                       rand16());
      n = $urandom_range(0, 3);
      for (int i = 0; i < n; i++) begin
         queue_request(CMD_SUBMIT, 16'(order[0]), rand16(), 1'($urandom), rand16());
         queue_request(CMD_POP_USED, rand16(), rand16(), 1'($urandom),
                       $urandom_range(0, 1) ? 16'($urandom_range(0, 3)) : rand16());
      end
      queue_request(CMD_FREE_CHAIN, 16'(order[0]), rand16(), 1'($urandom), rand16());
      if (split < k)
         queue_request(CMD_FREE_CHAIN, 16'(order[split]), rand16(), 1'($urandom), rand16());
      if (flaw <= 2)
         traffic_dirty = 1;
   endfunction

   function automatic void plan_traffic(int count);
      int goal;
      goal = request_backlog.size() + count;
      while (request_backlog.size() < goal) begin
         if ($urandom_range(0, 4) == 0)
            queue_noise();
         else
            queue_chain_traffic();
      end
   endfunction

   task automatic write_queue_number(logic [15:0] value);
      @(negedge clock);
      csr_write_enable <= 1;
      csr_write_data <= value;
      @(negedge clock);
      csr_write_enable <= 0;
      notify_qnum = value;
   endtask

   task automatic wait_drained();
      do
         @(posedge clock);
      while (request_backlog.size() != 0 || awaited_rsp.size() != 0 || req_valid);
      repeat (4) @(posedge clock);
   endtask

   function automatic void check_field(string name, logic [15:0] want, logic [15:0] got);
      if (want !== got) begin
         $display("%0t: %s expected %0h, got %0h", $time, name, want, got);
         fail_count++;
      end
   endfunction

   // request driver
   bit accepted_now = 0;
   int gap_left = 0;

   always @(posedge clock) begin
      accepted_now = !reset && req_valid && !req_stall;
      if (accepted_now) begin
         awaited_rsp.push_back(predict_response({req_command, req_desc_index, req_link_next,
                                                 req_link_has_next, req_device_used_idx}));
      end
   end

   always @(negedge clock) begin
      request_type next_req;
      bit          holding;
      holding = req_valid && !accepted_now;
      if (reset || holding) begin
      end else if (gap_left > 0) begin
         gap_left--;
         req_valid <= 0;
      end else if (request_backlog.size() > 0) begin
         next_req = request_backlog.pop_front();
         req_valid <= 1;
         req_command <= next_req.command;
         req_desc_index <= next_req.desc_index;
         req_link_next <= next_req.link_next;
         req_link_has_next <= next_req.link_has_next;
         req_device_used_idx <= next_req.device_used_idx;
         if (idle_on && $urandom_range(0, 3) == 0)
            gap_left = $urandom_range(1, 7);
      end else begin
         req_valid <= 0;
      end
   end

   // response side back-pressure
   int  stall_left = 0;
   int  hold_left = 0;
   bit  hold_taken = 0;

   always @(negedge clock) begin
      if (hold_arm && !hold_taken) begin
         hold_left <= HOLD_CYCLES;
         hold_taken <= 1;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
      end
   end

   always @(negedge clock) begin
      if (stall_left > 0)
         stall_left--;
      else if (idle_on && $urandom_range(0, 5) == 0)
         stall_left = $urandom_range(1, 7);
      rsp_stall <= (stall_left > 0) || (hold_left > 0);
   end

   // response monitor
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (awaited_rsp.size() == 0) begin
            $display("%0t: unexpected response, expected none, got %h", $time,
                     {rsp_status, rsp_granted_index, rsp_ring_slot, rsp_ring_index_after,
                      rsp_freed_count, rsp_notify_queue, rsp_notify_valid});
            fail_count++;
         end else begin
            want = awaited_rsp.pop_front();
            check_field("status", want.status, rsp_status);
            check_field("granted_index", want.granted_index, rsp_granted_index);
            check_field("ring_slot", want.ring_slot, rsp_ring_slot);
            check_field("ring_index_after", want.ring_index_after, rsp_ring_index_after);
            check_field("freed_count", want.freed_count, rsp_freed_count);
            check_field("notify_queue", want.notify_queue, rsp_notify_queue);
            check_field("notify_valid", want.notify_valid, rsp_notify_valid);
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("FAILED: results differ");
         $finish;
      end
   end

   initial begin
      clear_rings();
      notify_qnum = '0;
      repeat (10) @(negedge clock);
      reset <= 0;

      // directed: exhaust, loop in a chain, bad indexes, rings, unused code, reinit
      for (int i = 0; i <= NUM_DESC; i++)
         queue_request(CMD_ALLOC, '0, '0, 0, '0);
      queue_request(CMD_SET_LINK, 16'd0, 16'd1, 1, '0);
      queue_request(CMD_SET_LINK, 16'd1, 16'd2, 1, '0);
      queue_request(CMD_SET_LINK, 16'd2, 16'd0, 1, '0);
      queue_request(CMD_FREE_CHAIN, 16'd0, '0, 0, '0);
      queue_request(CMD_SET_LINK, 16'hFFFF, 16'hFFFF, 1, 16'hFFFF);
      queue_request(CMD_FREE, 16'd3, '0, 0, '0);
      queue_request(CMD_FREE, 16'd3, '0, 0, '0);
      queue_request(CMD_FREE, 16'hFFFF, 16'hFFFF, 1, 16'hFFFF);
      queue_request(CMD_FREE, 16'(NUM_DESC), '0, 0, '0);
      queue_request(CMD_SET_LINK, 16'd4, 16'hFFFF, 1, '0);
      queue_request(CMD_FREE_CHAIN, 16'd4, '0, 0, '0);
      queue_request(CMD_SUBMIT, 16'hFFFF, 16'hFFFF, 1, 16'hFFFF);
      queue_request(CMD_POP_USED, '0, '0, 0, 16'h0000);
      queue_request(CMD_POP_USED, '0, '0, 0, 16'hFFFF);
      queue_request(CMD_UNUSED, 16'hFFFF, 16'hFFFF, 1, 16'hFFFF);
      queue_request(CMD_REINIT, '0, '0, 0, '0);
      wait_drained();

      write_queue_number(16'hFFFF);
      idle_on = 1;
      plan_traffic(250);
      @(posedge clock);
      hold_arm = 1;
      wait_drained();

      write_queue_number(16'($urandom_range(2, 16'hFFFE)));
      plan_traffic(200);
      wait_drained();

      // no idling from here on
      idle_on = 0;
      write_queue_number(16'h0000);
      plan_traffic(100);
      wait_drained();
      repeat (30) @(posedge clock);

      if (fail_count == 0)
         $display("PASSED: all results match");
      else
         $display("FAILED: results differ");
      $finish;
   end

endmodule
